/* design/demand_paging_lru_translate_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the demand paging translator
// Implication checks, same cycle and next cycle, on the block clock.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGING_LRU_TRANSLATE_MACROS_SVH
`define DEMAND_PAGING_LRU_TRANSLATE_MACROS_SVH

`ifndef ASSERT_OFF
`define DPLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DPLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DPLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DPLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/dplt_pkg.sv */
// ----------------------------------------------------------------------------
// dplt_pkg
// Field widths and fixed constants of the demand paging translator.
// ----------------------------------------------------------------------------
`default_nettype none

package dplt_pkg;

  localparam int ADDR_W      = 12;
  localparam int PA_W        = 10;
  localparam int OFFSET_BITS = 7;
  localparam int STAMP_W     = 32;
  localparam int CNT_W       = 32;

  typedef logic [ADDR_W-1:0]  laddr_t;
  typedef logic [PA_W-1:0]    paddr_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [CNT_W-1:0]   count_t;

endpackage

`default_nettype wire

/* design/dplt_req_if.sv */
// ----------------------------------------------------------------------------
// dplt_req_if
// Request channel: one logical address per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dplt_req_if
  import dplt_pkg::*;
();
  logic   valid;
  logic   ready;
  laddr_t logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink   (input valid, input logical_address, output ready);
endinterface

`default_nettype wire

/* design/dplt_rsp_if.sv */
// ----------------------------------------------------------------------------
// dplt_rsp_if
// Result channel: physical address, fault flag and fault total per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dplt_rsp_if
  import dplt_pkg::*;
();
  logic   valid;
  logic   ready;
  paddr_t physical_address;
  logic   page_fault;
  count_t fault_total;

  modport source (output valid, output physical_address, output page_fault,
                  output fault_total, input ready);
  modport sink   (input valid, input physical_address, input page_fault,
                  input fault_total, output ready);
endinterface

`default_nettype wire

/* design/demand_paging_lru_translate.sv */
// ----------------------------------------------------------------------------
// demand_paging_lru_translate
// Page table lookup with demand allocation and least-recently-used eviction.
// ----------------------------------------------------------------------------
// One address is taken every cycle while the result channel does not stall. Its
// result is loaded from the input register into the result register, from
// which it is transferred, so the sustained rate is one item per clock. That
// figure is set by the update stage:
// page table read, victim choice by an all-pairs compare of the frame stamps,
// and the write-back of table, owner, stamp and counters in the same edge, so
// each item sees everything the previous one left. Frame 0 is never handed
// out; frames are allocated in ascending order until all are used, after
// which the frame with the smallest stamp (lowest index on ties) is evicted.
// A stalled result register holds the input register, which stalls the
// request channel; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "demand_paging_lru_translate_macros.svh"

module demand_paging_lru_translate
  import dplt_pkg::*;
#(
  parameter int PAGE_COUNT  = 32,
  parameter int FRAME_COUNT = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  dplt_req_if.sink   in_req,
  dplt_rsp_if.source out_rsp
);

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int NW = FW + 1;
  localparam int VW = ADDR_W - OFFSET_BITS;
  localparam int CW = FW + OFFSET_BITS;

  typedef logic [PW-1:0] page_t;
  typedef logic [FW-1:0] frame_t;
  typedef page_t page_map_t [2**VW];

  function automatic page_map_t build_page_map();
    page_map_t m;
    for (int i = 0; i < 2**VW; i++) begin
      m[i] = PW'(i % PAGE_COUNT);
    end
    return m;
  endfunction

  localparam page_map_t PAGE_MAP = build_page_map();

  logic                  req_valid_r;
  laddr_t                req_addr_r;
  logic                  rsp_valid_r;
  paddr_t                rsp_pa_r;
  logic                  rsp_fault_r;
  count_t                rsp_total_r;

  logic [PAGE_COUNT-1:0] page_valid_r;
  logic [PAGE_COUNT-1:0] page_valid_nxt;
  frame_t                page_frame_r [PAGE_COUNT];
  page_t                 owner_r      [FRAME_COUNT];
  stamp_t                stamp_r      [FRAME_COUNT];
  stamp_t                clock_r;
  logic [NW-1:0]         next_free_r;
  count_t                fault_cnt_r;

  logic                   advance;
  logic                   proc;
  logic [VW-1:0]          vpn;
  logic [OFFSET_BITS-1:0] offset;
  page_t                  page;
  logic                   hit;
  logic                   has_free;
  logic [FRAME_COUNT-1:0] oldest;
  frame_t                 victim;
  frame_t                 alloc_frame;
  frame_t                 frame;
  stamp_t                 stamp_nxt;
  logic [CW-1:0]          pa_full;
  paddr_t                 pa_nxt;
  count_t                 total_nxt;

  assign advance      = !rsp_valid_r || out_rsp.ready;
  assign proc         = req_valid_r && advance;
  assign in_req.ready = !req_valid_r || advance;

  assign vpn      = req_addr_r[ADDR_W-1:OFFSET_BITS];
  assign offset   = req_addr_r[OFFSET_BITS-1:0];
  assign page     = PAGE_MAP[vpn];
  assign hit      = page_valid_r[page];
  assign has_free = next_free_r < NW'(FRAME_COUNT);

  // frame i is oldest when strictly below all lower frames and not above any higher one
  always_comb begin
    oldest = '0;
    for (int i = 1; i < FRAME_COUNT; i++) begin
      oldest[i] = 1'b1;
      for (int j = 1; j < FRAME_COUNT; j++) begin
        if (j < i && !(stamp_r[i] < stamp_r[j])) begin
          oldest[i] = 1'b0;
        end
        if (j > i && stamp_r[j] < stamp_r[i]) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    victim = FW'(1);
    for (int i = 1; i < FRAME_COUNT; i++) begin
      if (oldest[i]) begin
        victim = FW'(i);
      end
    end
  end

  assign alloc_frame = has_free ? next_free_r[FW-1:0] : victim;
  assign frame       = hit ? page_frame_r[page] : alloc_frame;
  assign stamp_nxt   = clock_r + stamp_t'(1);
  assign pa_full     = {frame, offset};
  assign pa_nxt      = PA_W'(pa_full);
  assign total_nxt   = hit ? fault_cnt_r : fault_cnt_r + count_t'(1);

  always_comb begin
    page_valid_nxt = page_valid_r;
    if (proc && !hit) begin
      if (!has_free) begin
        page_valid_nxt[owner_r[victim]] = 1'b0;
      end
      page_valid_nxt[page] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r  <= 1'b0;
      rsp_valid_r  <= 1'b0;
      page_valid_r <= '0;
      clock_r      <= '0;
      next_free_r  <= NW'(1);
      fault_cnt_r  <= '0;
    end else begin
      page_valid_r <= page_valid_nxt;
      if (in_req.ready) begin
        req_valid_r <= in_req.valid;
      end
      if (advance) begin
        rsp_valid_r <= req_valid_r;
      end
      if (proc) begin
        clock_r <= stamp_nxt;
        if (!hit) begin
          fault_cnt_r <= total_nxt;
          if (has_free) begin
            next_free_r <= next_free_r + NW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      req_addr_r <= in_req.logical_address;
    end
    if (proc) begin
      rsp_pa_r       <= pa_nxt;
      rsp_fault_r    <= !hit;
      rsp_total_r    <= total_nxt;
      stamp_r[frame] <= stamp_nxt;
      if (!hit) begin
        page_frame_r[page]   <= alloc_frame;
        owner_r[alloc_frame] <= page;
      end
    end
  end

  assign out_rsp.valid            = rsp_valid_r;
  assign out_rsp.physical_address = rsp_pa_r;
  assign out_rsp.page_fault       = rsp_fault_r;
  assign out_rsp.fault_total      = rsp_total_r;

  `DPLT_ASSERT_NEXT(a_page_mapped, clk, rst_n, proc, page_valid_r[$past(page)], "accessed page not mapped")
  `DPLT_ASSERT_NEXT(a_fault_count, clk, rst_n, proc && !hit, fault_cnt_r == $past(fault_cnt_r) + 1'b1, "fault count not advanced")
  `DPLT_ASSERT_NEXT(a_hit_no_alloc, clk, rst_n, proc && hit, $stable(next_free_r) && $stable(fault_cnt_r), "hit changed allocation state")
  `DPLT_ASSERT_IMPL(a_rsp_source, clk, rst_n, $rose(rsp_valid_r), $past(proc), "result without processed request")

endmodule

`default_nettype wire
